// ===== hw/rtl/pdxd_pkg.sv =====
package pdxd_pkg;

	// Deframer phase codes. The fourth code is unused and behaves as the header phase.
	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_DROP    = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_MAGIC  = 3'd0;
	localparam logic [2:0] REG_TYPE_A = 3'd1;
	localparam logic [2:0] REG_TYPE_B = 3'd2;
	localparam logic [2:0] REG_KEY_0  = 3'd3;
	localparam logic [2:0] REG_KEY_1  = 3'd4;
	localparam logic [2:0] REG_KEY_2  = 3'd5;
	localparam logic [2:0] REG_KEY_3  = 3'd6;

	// Reset values of the configuration registers ("WGP1" and the default key).
	localparam logic [31:0] MAGIC_RST  = 32'h5747_5031;
	localparam logic [15:0] TYPE_A_RST = 16'd2;
	localparam logic [15:0] TYPE_B_RST = 16'd22;
	localparam logic [31:0] KEY_0_RST  = 32'h677F_7147;
	localparam logic [31:0] KEY_1_RST  = 32'h4F49_6143;
	localparam logic [31:0] KEY_2_RST  = 32'h6D3D_836B;
	localparam logic [31:0] KEY_3_RST  = 32'h5359_653B;

	// Header is eight bytes; the count wraps after the last one.
	localparam logic [2:0] HDR_LAST = 3'd7;

	// Four key words, word 0 in the lowest bits, byte 0 of each word lowest.
	typedef logic [3:0][31:0] key_words_t;

endpackage

// ===== hw/rtl/pdxd_key_sel.sv =====
module pdxd_key_sel #(
	parameter int KEY_BYTES = 16,
	parameter int KIDX_W    = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1
) (
	input  pdxd_pkg::key_words_t keys,
	input  logic [KIDX_W-1:0]    idx,
	input  logic [7:0]           raw_byte,
	output logic [7:0]           clear_byte
);
	import pdxd_pkg::*;

	logic [3:0] k;
	logic [7:0] key_byte;

	// The index never exceeds fifteen, so it fits the four-bit byte address of the key.
	assign k          = 4'(idx);
	assign key_byte   = keys[k[3:2]][{k[1:0], 3'b000} +: 8];
	assign clear_byte = raw_byte ^ key_byte;

endmodule

// ===== hw/rtl/packet_deframer_xor_descrambler.sv =====
// Packet deframer with XOR descrambling.
// The slave stream takes one received byte per beat in s_axis_tdata, with
// s_axis_tlast marking the last byte of a received chunk. Each packet is an
// eight-byte header (four magic bytes, big-endian type, big-endian length)
// followed by the payload. Every payload byte leaves on the master stream
// XORed with the rolling key, tagged with the packet type, and m_axis_tlast
// marks the final byte of the message. A header with zero length yields one
// empty-message beat; a bad magic or type yields one error beat, after which
// input is discarded through the end of the chunk.
// Each result beat appears in the cycle after its byte is accepted, and one
// byte is accepted every cycle unless the output stalls: the whole decision
// is made in the logic between the state registers and the single output
// register. While the receiver stalls with a result pending, s_axis_tready
// drops, so input waits whenever the output register holds a beat that has
// not been taken, even for a byte that would produce no result.
// Reset returns the deframer to the start of a header and loads the default
// magic, types and key. The configuration port is always ready; the user must
// write it only while the stream is idle, which the block does not enforce.
module packet_deframer_xor_descrambler #(
	parameter int KEY_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Slave stream. tdata: in_byte[7:0]. tlast: chunk_end.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tlast,
	// Master stream. tdata: data_byte[7:0], msg_type[23:8]. tuser: kind[1:0].
	// tlast: last_of_message.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import pdxd_pkg::*;

	localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

	// Configuration registers.
	logic [31:0] magic_q;
	logic [15:0] type_a_q;
	logic [15:0] type_b_q;
	key_words_t  keys_q;

	// Deframer state.
	logic [1:0]        phase_q;
	logic [2:0]        hdr_cnt_q;
	logic [15:0]       msg_type_q;
	logic [15:0]       msg_len_q;
	logic [15:0]       pay_idx_q;
	logic [KIDX_W-1:0] key_idx_q;
	logic              mismatch_q;

	// Output register.
	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [7:0]  out_data_q;
	logic [15:0] out_type_q;
	logic        out_last_q;

	// Next state and result.
	logic [1:0]        phase_d;
	logic [2:0]        hdr_cnt_d;
	logic [15:0]       msg_type_d;
	logic [15:0]       msg_len_d;
	logic [15:0]       pay_idx_d;
	logic [KIDX_W-1:0] key_idx_d;
	logic              mismatch_d;
	logic              res_valid;
	logic [1:0]        res_kind;
	logic [7:0]        res_data;
	logic              res_last;

	logic       in_accept;
	logic       pay_last;
	logic [7:0] clear_byte;
	logic [7:0] want_byte;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q  <= MAGIC_RST;
			type_a_q <= TYPE_A_RST;
			type_b_q <= TYPE_B_RST;
			keys_q   <= {KEY_3_RST, KEY_2_RST, KEY_1_RST, KEY_0_RST};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAGIC:  magic_q   <= cfg_data;
				REG_TYPE_A: type_a_q  <= cfg_data[15:0];
				REG_TYPE_B: type_b_q  <= cfg_data[15:0];
				REG_KEY_0:  keys_q[0] <= cfg_data;
				REG_KEY_1:  keys_q[1] <= cfg_data;
				REG_KEY_2:  keys_q[2] <= cfg_data;
				REG_KEY_3:  keys_q[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pdxd_key_sel #(
		.KEY_BYTES (KEY_BYTES),
		.KIDX_W    (KIDX_W)
	) u_key_sel (
		.keys       (keys_q),
		.idx        (key_idx_q),
		.raw_byte   (s_axis_tdata),
		.clear_byte (clear_byte)
	);

	// Magic bytes arrive most significant first.
	assign want_byte = magic_q[{~hdr_cnt_q[1:0], 3'b000} +: 8];
	assign pay_last  = ({1'b0, pay_idx_q} + 17'd1) >= {1'b0, msg_len_q};

	always_comb begin
		phase_d    = phase_q;
		hdr_cnt_d  = hdr_cnt_q;
		msg_type_d = msg_type_q;
		msg_len_d  = msg_len_q;
		pay_idx_d  = pay_idx_q;
		key_idx_d  = key_idx_q;
		mismatch_d = mismatch_q;
		res_valid  = 1'b0;
		res_kind   = KIND_DATA;
		res_data   = 8'd0;
		res_last   = 1'b0;
		unique case (phase_q)
			PH_DROP: begin
				if (s_axis_tlast) begin
					phase_d = PH_HEADER;
				end
			end
			PH_PAYLOAD: begin
				res_valid = 1'b1;
				res_data  = clear_byte;
				res_last  = pay_last;
				pay_idx_d = pay_idx_q + 16'd1;
				key_idx_d = (key_idx_q == KIDX_W'(KEY_BYTES - 1)) ? '0 :
					key_idx_q + KIDX_W'(1);
				if (pay_last) begin
					phase_d = PH_HEADER;
				end
			end
			default: begin
				phase_d = PH_HEADER;
				if (!hdr_cnt_q[2]) begin
					if (want_byte != s_axis_tdata) begin
						mismatch_d = 1'b1;
					end
				end else if (!hdr_cnt_q[1]) begin
					msg_type_d = {msg_type_q[7:0], s_axis_tdata};
				end else begin
					msg_len_d = {msg_len_q[7:0], s_axis_tdata};
				end
				if (hdr_cnt_q != HDR_LAST) begin
					hdr_cnt_d = hdr_cnt_q + 3'd1;
				end else begin
					// Eighth byte: judge the whole header.
					hdr_cnt_d  = 3'd0;
					mismatch_d = 1'b0;
					if (mismatch_q || (msg_type_q != type_a_q && msg_type_q != type_b_q)) begin
						res_valid = 1'b1;
						res_kind  = KIND_ERROR;
						phase_d   = s_axis_tlast ? PH_HEADER : PH_DROP;
					end else if (msg_len_d == 16'd0) begin
						res_valid = 1'b1;
						res_kind  = KIND_EMPTY;
						res_last  = 1'b1;
					end else begin
						pay_idx_d = 16'd0;
						key_idx_d = '0;
						phase_d   = PH_PAYLOAD;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hdr_cnt_q  <= 3'd0;
			msg_type_q <= 16'd0;
			msg_len_q  <= 16'd0;
			pay_idx_q  <= 16'd0;
			key_idx_q  <= '0;
			mismatch_q <= 1'b0;
		end else if (in_accept) begin
			phase_q    <= phase_d;
			hdr_cnt_q  <= hdr_cnt_d;
			msg_type_q <= msg_type_d;
			msg_len_q  <= msg_len_d;
			pay_idx_q  <= pay_idx_d;
			key_idx_q  <= key_idx_d;
			mismatch_q <= mismatch_d;
		end
	end

	// The output register is free or being emptied whenever a byte is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= res_valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && res_valid) begin
			out_kind_q <= res_kind;
			out_data_q <= res_data;
			out_type_q <= msg_type_d;
			out_last_q <= res_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_type_q, out_data_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_hdr_cnt_phase: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q != 3'd0 |-> phase_q == PH_HEADER)
		else $error("header count advanced outside the header phase");

	a_unused_phase: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("deframer reached the unused phase code");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_ERROR |-> !m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
		else $error("error beat carries data or a last mark");

	a_payload_end: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && phase_q == PH_PAYLOAD && pay_last |=> phase_q == PH_HEADER && m_axis_tlast)
		else $error("final payload byte did not close the message");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_axis_tready)
		else $error("input stalled with an empty output register");
`endif

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pdxd_pkg::*;

	// The deframer decodes three register bits, so index seven exists on the
	// port but selects nothing. A write there must leave every register alone.
	localparam logic [2:0] REG_UNUSED = 3'd7;

	localparam int KEY_BYTES      = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 200;

	// One received byte as it travels on the slave stream.
	typedef struct packed {
		logic [7:0] value;
		logic       chunk_end;
	} line_byte_t;

	// One deframed result as it should leave on the master stream.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [15:0] msg_type;
		logic        last_of_msg;
	} deframed_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index     = REG_MAGIC;
	logic [31:0] cfg_data      = 32'h0;

	// Bytes waiting for the driver, and results the deframer still owes us.
	line_byte_t line_bytes[$];
	deframed_t  deframed_q[$];
	int         bytes_queued   = 0;

	// Percent chance per cycle that the sender idles or the receiver stalls.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// Set by the monitor when the driver's current beat was taken at the
	// rising edge, consumed by the driver at the following falling edge.
	logic tx_taken     = 1'b0;
	int   fail_count   = 0;
	int   quiet_cycles = 0;

	// Shadow copy of the configuration registers, kept in step with the
	// writes seen on the configuration channel.
	logic [31:0] shadow_magic  = MAGIC_RST;
	logic [15:0] shadow_type_a = TYPE_A_RST;
	logic [15:0] shadow_type_b = TYPE_B_RST;
	key_words_t  shadow_key    = {KEY_3_RST, KEY_2_RST, KEY_1_RST, KEY_0_RST};

	// Shadow copy of the deframer state.
	logic [1:0]  st_phase     = PH_HEADER;
	logic [2:0]  st_hdr_count = 3'd0;
	logic [15:0] st_type      = 16'h0;
	logic [15:0] st_length    = 16'h0;
	logic [15:0] st_index     = 16'h0;
	logic        st_bad_magic = 1'b0;

	packet_deframer_xor_descrambler u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advances the shadow deframer by one received byte and queues the result
	// that byte should produce, if any. The header is judged on its eighth
	// byte, the magic bytes are compared one at a time as they arrive.
	task automatic deframe_byte(input logic [7:0] b, input logic cend);
		deframed_t   res;
		logic [2:0]  n;
		int          k;
		if (st_phase == PH_DROP) begin
			// Discarding after a framing error; only the chunk end matters.
			if (cend)
				st_phase = PH_HEADER;
		end else if (st_phase == PH_PAYLOAD) begin
			k = int'(st_index) % KEY_BYTES;
			res.kind        = KIND_DATA;
			res.data_byte   = b ^ shadow_key[k / 4][8 * (k % 4) +: 8];
			res.msg_type    = st_type;
			res.last_of_msg = (int'(st_index) + 1 >= int'(st_length));
			deframed_q.push_back(res);
			st_index = st_index + 16'd1;
			if (res.last_of_msg)
				st_phase = PH_HEADER;
		end else begin
			// Header phase; the unused phase code lands here as well.
			st_phase = PH_HEADER;
			n = st_hdr_count;
			if (n < 3'd4) begin
				if (shadow_magic[8 * (3 - int'(n)) +: 8] != b)
					st_bad_magic = 1'b1;
			end else if (n < 3'd6) begin
				st_type = {st_type[7:0], b};
			end else begin
				st_length = {st_length[7:0], b};
			end
			if (n != HDR_LAST) begin
				st_hdr_count = n + 3'd1;
			end else begin
				st_hdr_count = 3'd0;
				if (st_bad_magic || (st_type != shadow_type_a && st_type != shadow_type_b)) begin
					res = '{KIND_ERROR, 8'h00, st_type, 1'b0};
					deframed_q.push_back(res);
					// An error on a chunk's last byte has nothing left to drop.
					st_phase = cend ? PH_HEADER : PH_DROP;
				end else if (st_length == 16'h0) begin
					res = '{KIND_EMPTY, 8'h00, st_type, 1'b1};
					deframed_q.push_back(res);
				end else begin
					st_index = 16'h0;
					st_phase = PH_PAYLOAD;
				end
				st_bad_magic = 1'b0;
			end
		end
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
	endtask

	// Monitor: every handshake is taken from values settled since the falling
	// edge, so nothing here depends on the order of events at the rising edge.
	always @(posedge clk) begin : monitor
		deframed_t want;
		logic      any_beat;
		if (arst_n) begin
			any_beat = 1'b0;
			if (cfg_valid && cfg_ready) begin
				any_beat = 1'b1;
				case (cfg_index)
					REG_MAGIC:  shadow_magic  = cfg_data;
					REG_TYPE_A: shadow_type_a = cfg_data[15:0];
					REG_TYPE_B: shadow_type_b = cfg_data[15:0];
					REG_KEY_0:  shadow_key[0] = cfg_data;
					REG_KEY_1:  shadow_key[1] = cfg_data;
					REG_KEY_2:  shadow_key[2] = cfg_data;
					REG_KEY_3:  shadow_key[3] = cfg_data;
					default: begin
					end
				endcase
			end
			// Predict before checking, so a result is never looked for ahead
			// of the byte that causes it.
			if (s_axis_tvalid && s_axis_tready) begin
				any_beat = 1'b1;
				tx_taken = 1'b1;
				deframe_byte(s_axis_tdata, s_axis_tlast);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				any_beat = 1'b1;
				if (deframed_q.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$error("result beat with no result expected: tuser 0x%0h tdata 0x%0h",
							m_axis_tuser, m_axis_tdata);
				end else begin
					want = deframed_q.pop_front();
					if (m_axis_tuser !== want.kind)
						report_mismatch("kind", want.kind, m_axis_tuser);
					if (m_axis_tdata[7:0] !== want.data_byte)
						report_mismatch("data_byte", want.data_byte, m_axis_tdata[7:0]);
					if (m_axis_tdata[23:8] !== want.msg_type)
						report_mismatch("msg_type", want.msg_type, m_axis_tdata[23:8]);
					if (m_axis_tlast !== want.last_of_msg)
						report_mismatch("last_of_message", want.last_of_msg, m_axis_tlast);
				end
			end
			// A hung handshake on any channel ends the run here.
			quiet_cycles = any_beat ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[packet_deframer_xor_descrambler] ERROR");
				$finish;
			end
		end
	end

	// Driver: a beat stays on the bus until it is taken; only then may the
	// sender go idle or present the next byte. The receiver stalls at random.
	always @(negedge clk) begin : driver
		line_byte_t nb;
		if (arst_n && (!s_axis_tvalid || tx_taken)) begin
			tx_taken = 1'b0;
			if (line_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nb = line_bytes.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= nb.value;
				s_axis_tlast  <= nb.chunk_end;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic push_byte(input logic [7:0] value, input logic cend);
		line_bytes.push_back('{value, cend});
		bytes_queued++;
	endtask

	// Eight header bytes; bit i of cend_mask marks header byte i as a chunk end.
	task automatic push_header(input logic [31:0] magic, input logic [15:0] mtype,
			input logic [15:0] len, input logic [7:0] cend_mask);
		logic [63:0] hdr;
		hdr = {magic, mtype, len};
		for (int i = 0; i < 8; i++)
			push_byte(hdr[63 - 8 * i -: 8], cend_mask[i]);
	endtask

	// Chunk ends inside a header or a payload are ignored by the deframer, so
	// well-formed packets carry them at random.
	function automatic logic [7:0] stray_chunk_ends();
		logic [7:0] mask;
		for (int i = 0; i < 8; i++)
			mask[i] = ($urandom_range(7) == 0);
		return mask;
	endfunction

	task automatic send_good_packet(input logic [15:0] len);
		logic [15:0] mtype;
		mtype = $urandom_range(1) ? shadow_type_a : shadow_type_b;
		push_header(shadow_magic, mtype, len, stray_chunk_ends());
		for (int i = 0; i < int'(len); i++)
			push_byte(8'($urandom), $urandom_range(7) == 0);
	endtask

	// A header that fails on its magic or on its type, followed by the bytes
	// that get dropped up to the end of the chunk. With no tail the chunk ends
	// on the eighth header byte itself.
	task automatic send_bad_packet(input logic bad_magic, input int tail_len);
		logic [31:0] magic;
		logic [15:0] mtype;
		logic [7:0]  mask;
		magic = shadow_magic;
		if (bad_magic) begin
			magic = magic ^ (32'($urandom_range(255, 1)) << (8 * $urandom_range(3)));
			mtype = 16'($urandom);
		end else begin
			do
				mtype = 16'($urandom);
			while (mtype == shadow_type_a || mtype == shadow_type_b);
		end
		mask = stray_chunk_ends();
		mask[7] = (tail_len == 0);
		push_header(magic, mtype, 16'($urandom), mask);
		for (int i = 0; i < tail_len; i++)
			push_byte(8'($urandom), i == tail_len - 1);
	endtask

	// Mostly well-formed packets with random content, the rest broken headers
	// and line noise. Every kind of sequence leaves the deframer at the start
	// of a header, so the following packets stay aligned.
	task automatic send_traffic(input int items);
		int stop_at;
		int pick;
		int len;
		stop_at = bytes_queued + items;
		while (bytes_queued < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				if ($urandom_range(9) == 0)
					len = 0;
				else if ($urandom_range(19) == 0)
					len = $urandom_range(80, 21);
				else
					len = $urandom_range(20, 1);
				send_good_packet(16'(len));
			end else if (pick < 80) begin
				send_bad_packet(1'b1, $urandom_range(12));
			end else if (pick < 90) begin
				send_bad_packet(1'b0, $urandom_range(12));
			end else begin
				// Noise: random bytes read as a bad header, then dropped.
				len = $urandom_range(20, 8);
				for (int i = 0; i < len; i++)
					push_byte(8'($urandom), i == len - 1);
			end
		end
	endtask

	// Holds the sender back until every queued byte is taken and every result
	// has arrived.
	task automatic drain();
		while (line_bytes.size() != 0 || s_axis_tvalid || deframed_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Each phase pauses the sender halfway until all results are in.
	task automatic run_phase(input int send_pct, input int stall_pct, input int items);
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		send_traffic(items / 2);
		drain();
		send_traffic(items - items / 2);
		drain();
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset configuration, no idling.
		// Empty message on the second allowed type.
		push_header(shadow_magic, shadow_type_b, 16'h0000, 8'h00);
		// One-byte payload right behind it, with chunk ends that must be
		// ignored inside the header and on the payload byte.
		push_header(shadow_magic, shadow_type_a, 16'h0001, 8'b0001_0001);
		push_byte(8'hFF, 1'b1);
		// Bad type with the chunk ending on the eighth header byte: nothing
		// is dropped, the next byte starts a header.
		push_header(shadow_magic, 16'hFFFF, 16'hFFFF, 8'h80);
		// Bad magic followed by one dropped byte that ends the chunk.
		push_header(shadow_magic ^ 32'h0000_FF00, shadow_type_a, 16'h0003, 8'h00);
		push_byte(8'h00, 1'b1);
		drain();
		// A payload long enough to wrap the key several times and carry the
		// byte index past eight bits.
		send_good_packet(16'd300);
		run_phase(0, 0, 110);

		// Random registers, and a write to the undecoded index in between.
		write_reg(REG_MAGIC, $urandom);
		write_reg(REG_TYPE_A, 32'($urandom_range(65535)));
		write_reg(REG_UNUSED, $urandom);
		write_reg(REG_TYPE_B, 32'($urandom_range(65535)));
		write_reg(REG_KEY_0, $urandom);
		write_reg(REG_KEY_1, $urandom);
		write_reg(REG_KEY_2, $urandom);
		write_reg(REG_KEY_3, $urandom);
		run_phase(87, 0, 120);

		// Extreme register values: all-ones magic, the lowest and highest
		// types, and keys of all ones and all zeros.
		write_reg(REG_MAGIC, 32'hFFFF_FFFF);
		write_reg(REG_TYPE_A, 32'h0000_0000);
		write_reg(REG_TYPE_B, 32'h0000_FFFF);
		write_reg(REG_KEY_0, 32'hFFFF_FFFF);
		write_reg(REG_KEY_1, 32'h0000_0000);
		write_reg(REG_KEY_2, 32'hFFFF_FFFF);
		write_reg(REG_KEY_3, 32'h0000_0000);
		run_phase(0, 87, 120);

		// All-zero magic and both allowed types the same value.
		write_reg(REG_MAGIC, 32'h0000_0000);
		write_reg(REG_TYPE_A, 32'h0000_1234);
		write_reg(REG_TYPE_B, 32'h0000_1234);
		write_reg(REG_KEY_0, $urandom);
		write_reg(REG_KEY_1, $urandom);
		write_reg(REG_KEY_2, $urandom);
		write_reg(REG_KEY_3, $urandom);
		run_phase(22, 22, 120);

		// Let a late or extra result beat show up before the verdict.
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("[packet_deframer_xor_descrambler] OK");
		end else begin
			$display("[packet_deframer_xor_descrambler] ERROR");
		end
		$finish;
	end

endmodule
